// ----- hw/rtl/euler_rotate_scale_translate_macros.svh -----
// ---------------------------------------------------------------------------
// Euler transform assertion macros
// Concurrent assertion helpers shared by the RTL, removable with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef EULER_ROTATE_SCALE_TRANSLATE_MACROS_SVH
`define EULER_ROTATE_SCALE_TRANSLATE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ERST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("erst: same-cycle implication failed");
`define ERST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("erst: next-cycle implication failed");
`else
`define ERST_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ERST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/erst_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Euler transform package
// Shared constants and types for the vertex rotate/scale/translate pipeline.
// ---------------------------------------------------------------------------
package erst_pkg;

   localparam int TRIG_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int SINE_LAT   = 7;

   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [31:0] SIN_F       = 32'd3864;
   localparam logic [15:0] SCALE_RESET = 16'd655;

   // Horner coefficients, innermost first: E, D, C, B, A
   localparam logic [31:0] SIN_COEF [5] = '{
      32'd172272, 32'd5026994, 32'd85569305, 32'd693598667, 32'd1686629713
   };

   localparam logic REG_SCALE = 1'b0;

   typedef struct packed {
      logic [30:0] x;
      logic [30:0] z;
      logic [1:0]  quad;
   } sine_carry_type;

endpackage

// ----- hw/rtl/euler_rotate_scale_translate.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Euler rotate/scale/translate
// Rotates a vertex about X, Y, Z, then scales and offsets positions.
// ---------------------------------------------------------------------------
// Channel   Ports                       Handshake
// request   start/busy, req_*           accepted when start && !busy
// result    rsp_strobe, rsp_*           one-cycle strobe, no back-pressure
// config    csr_* (APB)                 write on psel&penable&pwrite&pready
//
// One request per cycle; busy is never raised.
// Path: sine units, then the X, Y and Z rotation cells, then the scale cells.
// Y and Z angles pass the ay_ff and az_ff delay lines before their sine units to line up.
// Reset clears the valid pipe and sets scale to 655; no clearing pass.
// ---------------------------------------------------------------------------
`include "euler_rotate_scale_translate_macros.svh"
module euler_rotate_scale_translate #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COORD_WIDTH-1:0]     req_vert_x,
   input  logic signed [COORD_WIDTH-1:0]     req_vert_y,
   input  logic signed [COORD_WIDTH-1:0]     req_vert_z,
   input  logic [ANGLE_WIDTH-1:0]            req_angle_x,
   input  logic [ANGLE_WIDTH-1:0]            req_angle_y,
   input  logic [ANGLE_WIDTH-1:0]            req_angle_z,
   input  logic signed [COORD_WIDTH-1:0]     req_center_x,
   input  logic signed [COORD_WIDTH-1:0]     req_center_y,
   input  logic signed [COORD_WIDTH-1:0]     req_center_z,
   input  logic                              req_is_normal,
   input  logic                              req_in_last,
   output logic                              rsp_strobe,
   output logic signed [COORD_WIDTH-1:0]     rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]     rsp_out_z,
   output logic                              rsp_out_normal,
   output logic                              rsp_out_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [erst_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import erst_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int AW    = ANGLE_WIDTH;
   localparam int LAT   = SINE_LAT + 8;
   localparam int XD    = SINE_LAT + 2;
   localparam int SIDED = LAT - 1;

   localparam logic [AW-1:0] QUARTER = {2'b01, {(AW-2){1'b0}}};

   logic            accept;
   logic            csr_wr;
   logic [15:0]     scale_in, scale_ff;
   logic [LAT-1:0]  valid_in, valid_ff;

   logic [AW-1:0]   ay_ff [2];
   logic [AW-1:0]   az_ff [4];
   logic signed [CW-1:0]   y_ff [SINE_LAT];
   logic signed [CW-1:0]   z_ff [SINE_LAT];
   logic signed [CW-1:0]   x_ff [XD];
   logic signed [CW:0]     ny_ff [2];
   logic signed [CW+1:0]   nz_ff [2];
   logic [3*CW-1:0]        ctr_ff [SIDED];
   logic [1:0]             flag_ff [LAT];

   logic signed [TRIG_W-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
   logic signed [CW:0]   rx_u, rx_v;
   logic signed [CW+1:0] ry_u, ry_v;
   logic signed [CW+2:0] rz_u, rz_v;
   logic [3*CW-1:0]      ctr_out;
   logic [1:0]           flag_s;

   assign busy       = 1'b0;
   assign accept     = start && !busy;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // configuration
   always_comb begin
      scale_in = scale_ff;
      if (csr_wr && csr_paddr[2] == REG_SCALE) begin
         scale_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SCALE: csr_prdata = {16'b0, scale_ff};
         default:   csr_prdata = 32'b0;
      endcase
   end

   // valid pipe
   assign valid_in = {valid_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_strobe = valid_ff[LAT-1];

   // alignment lines
   always_ff @(posedge clock) begin
      ay_ff[0] <= req_angle_y;
      ay_ff[1] <= ay_ff[0];
      az_ff[0] <= req_angle_z;
      for (int i = 1; i < 4; i++) begin
         az_ff[i] <= az_ff[i-1];
      end
      y_ff[0] <= req_vert_y;
      z_ff[0] <= req_vert_z;
      for (int i = 1; i < SINE_LAT; i++) begin
         y_ff[i] <= y_ff[i-1];
         z_ff[i] <= z_ff[i-1];
      end
      x_ff[0] <= req_vert_x;
      for (int i = 1; i < XD; i++) begin
         x_ff[i] <= x_ff[i-1];
      end
      ny_ff[0] <= rx_u;
      ny_ff[1] <= ny_ff[0];
      nz_ff[0] <= ry_u;
      nz_ff[1] <= nz_ff[0];
      ctr_ff[0] <= {req_center_x, req_center_y, req_center_z};
      for (int i = 1; i < SIDED; i++) begin
         ctr_ff[i] <= ctr_ff[i-1];
      end
      flag_ff[0] <= {req_is_normal, req_in_last};
      for (int i = 1; i < LAT; i++) begin
         flag_ff[i] <= flag_ff[i-1];
      end
   end

   // sine and cosine lanes
   erst_sine #(.ANGLE_WIDTH(AW)) u_sin_x (
      .clock(clock), .angle(req_angle_x), .sine(sin_x));
   erst_sine #(.ANGLE_WIDTH(AW)) u_cos_x (
      .clock(clock), .angle(req_angle_x + QUARTER), .sine(cos_x));
   erst_sine #(.ANGLE_WIDTH(AW)) u_sin_y (
      .clock(clock), .angle(ay_ff[1]), .sine(sin_y));
   erst_sine #(.ANGLE_WIDTH(AW)) u_cos_y (
      .clock(clock), .angle(ay_ff[1] + QUARTER), .sine(cos_y));
   erst_sine #(.ANGLE_WIDTH(AW)) u_sin_z (
      .clock(clock), .angle(az_ff[3]), .sine(sin_z));
   erst_sine #(.ANGLE_WIDTH(AW)) u_cos_z (
      .clock(clock), .angle(az_ff[3] + QUARTER), .sine(cos_z));

   // X: (y, z) -> (ny, nz)
   erst_rot_cell #(.IN_W(CW)) u_rot_x (
      .clock(clock), .a(y_ff[SINE_LAT-1]), .b(z_ff[SINE_LAT-1]),
      .cs(cos_x), .sn(sin_x), .u(rx_u), .v(rx_v));

   // Y: (nz, x) -> (nz', nx)
   erst_rot_cell #(.IN_W(CW+1)) u_rot_y (
      .clock(clock), .a(rx_v), .b({x_ff[XD-1][CW-1], x_ff[XD-1]}),
      .cs(cos_y), .sn(sin_y), .u(ry_u), .v(ry_v));

   // Z: (nx, ny) -> (nx', ny')
   erst_rot_cell #(.IN_W(CW+2)) u_rot_z (
      .clock(clock), .a(ry_v), .b({ny_ff[1][CW], ny_ff[1]}),
      .cs(cos_z), .sn(sin_z), .u(rz_u), .v(rz_v));

   assign ctr_out = ctr_ff[SIDED-1];
   assign flag_s  = flag_ff[LAT-2];

   erst_scale_cell #(.COORD_WIDTH(CW)) u_scale_x (
      .clock(clock), .v(rz_u), .scale(scale_ff),
      .center(ctr_out[3*CW-1:2*CW]), .normal(flag_s[1]), .out(rsp_out_x));
   erst_scale_cell #(.COORD_WIDTH(CW)) u_scale_y (
      .clock(clock), .v(rz_v), .scale(scale_ff),
      .center(ctr_out[2*CW-1:CW]), .normal(flag_s[1]), .out(rsp_out_y));
   erst_scale_cell #(.COORD_WIDTH(CW)) u_scale_z (
      .clock(clock), .v({nz_ff[1][CW+1], nz_ff[1]}), .scale(scale_ff),
      .center(ctr_out[CW-1:0]), .normal(flag_s[1]), .out(rsp_out_z));

   assign rsp_out_normal = flag_ff[LAT-1][1];
   assign rsp_out_last   = flag_ff[LAT-1][0];

   `ERST_ASSERT_IMPLY(a_latency, clock, reset, accept, ##LAT rsp_strobe)
   `ERST_ASSERT_IMPLY(a_source, clock, reset, rsp_strobe, $past(accept, LAT))
   `ERST_ASSERT_NEXT(a_drain, clock, reset, valid_ff == '0 && !accept, !rsp_strobe)
endmodule

// ----- hw/rtl/erst_horner_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Horner cell
// One registered step t' = COEF - floor(z * t / 2^30) of the sine polynomial.
// ---------------------------------------------------------------------------
module erst_horner_cell #(
   parameter logic [31:0] COEF = 32'd0
) (
   input  logic                    clock,
   input  erst_pkg::sine_carry_type carry_i,
   input  logic signed [31:0]      t_i,
   output erst_pkg::sine_carry_type carry_o,
   output logic signed [31:0]      t_o
);
   import erst_pkg::*;

   logic signed [63:0] prod;
   logic signed [63:0] prod_sh;
   logic signed [31:0] t_in;
   logic signed [31:0] t_ff;
   sine_carry_type     carry_ff;

   assign prod    = $signed({1'b0, carry_i.z}) * t_i;
   assign prod_sh = prod >>> 30;
   assign t_in    = $signed(COEF) - prod_sh[31:0];

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      carry_ff <= carry_i;
   end

   assign t_o     = t_ff;
   assign carry_o = carry_ff;
endmodule

// ----- hw/rtl/erst_sine.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sine unit
// Pipelined Q30 sine of a binary angle: square, five Horner cells, final
// multiply with clamp and quadrant sign.
// ---------------------------------------------------------------------------
module erst_sine #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                            clock,
   input  logic [ANGLE_WIDTH-1:0]          angle,
   output logic signed [erst_pkg::TRIG_W-1:0] sine
);
   import erst_pkg::*;

   logic [1:0]         quad;
   logic [29:0]        xr;
   logic [30:0]        x;
   logic [61:0]        sq;
   sine_carry_type     carry_in;
   sine_carry_type     carry_ff;
   sine_carry_type     chain_carry [6];
   logic signed [31:0] chain_t     [6];
   logic signed [63:0] fin_prod;
   logic signed [63:0] fin_sh;
   logic signed [31:0] mag;
   logic signed [31:0] s_in;
   logic signed [31:0] s_ff;

   assign quad = angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
   assign xr   = {angle[ANGLE_WIDTH-3:0], {(32-ANGLE_WIDTH){1'b0}}};
   assign x    = quad[0] ? (Q30_ONE - {1'b0, xr}) : {1'b0, xr};
   assign sq   = {31'b0, x} * {31'b0, x};

   assign carry_in.x    = x;
   assign carry_in.z    = sq[60:30];
   assign carry_in.quad = quad;

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   assign chain_carry[0] = carry_ff;
   assign chain_t[0]     = $signed(SIN_F);

   for (genvar i = 0; i < 5; i++) begin : g_cell
      erst_horner_cell #(.COEF(SIN_COEF[i])) u_cell (
         .clock   (clock),
         .carry_i (chain_carry[i]),
         .t_i     (chain_t[i]),
         .carry_o (chain_carry[i+1]),
         .t_o     (chain_t[i+1])
      );
   end

   assign fin_prod = $signed({1'b0, chain_carry[5].x}) * chain_t[5];
   assign fin_sh   = fin_prod >>> 30;

   always_comb begin
      mag = fin_sh[31:0];
      if (mag > $signed({1'b0, Q30_ONE})) begin
         mag = $signed({1'b0, Q30_ONE});
      end
      s_in = chain_carry[5].quad[1] ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

   assign sine = s_ff;
endmodule

// ----- hw/rtl/erst_rot_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rotation cell
// Plane rotation u = a*c - b*s, v = a*s + b*c with floored Q30 products.
// Two register stages: products, then sums. Output one bit wider.
// ---------------------------------------------------------------------------
module erst_rot_cell #(
   parameter int IN_W = 32
) (
   input  logic                                clock,
   input  logic signed [IN_W-1:0]              a,
   input  logic signed [IN_W-1:0]              b,
   input  logic signed [erst_pkg::TRIG_W-1:0]  cs,
   input  logic signed [erst_pkg::TRIG_W-1:0]  sn,
   output logic signed [IN_W:0]                u,
   output logic signed [IN_W:0]                v
);
   import erst_pkg::*;

   localparam int PW = IN_W + TRIG_W;

   logic signed [PW-1:0] m_ac, m_bs, m_as, m_bc;
   logic signed [PW-1:0] s_ac, s_bs, s_as, s_bc;
   logic signed [IN_W:0] p_ac_ff, p_bs_ff, p_as_ff, p_bc_ff;
   logic signed [IN_W:0] u_in, v_in, u_ff, v_ff;

   assign m_ac = a * cs;
   assign m_bs = b * sn;
   assign m_as = a * sn;
   assign m_bc = b * cs;
   assign s_ac = m_ac >>> 30;
   assign s_bs = m_bs >>> 30;
   assign s_as = m_as >>> 30;
   assign s_bc = m_bc >>> 30;

   always_ff @(posedge clock) begin
      p_ac_ff <= s_ac[IN_W:0];
      p_bs_ff <= s_bs[IN_W:0];
      p_as_ff <= s_as[IN_W:0];
      p_bc_ff <= s_bc[IN_W:0];
   end

   assign u_in = p_ac_ff - p_bs_ff;
   assign v_in = p_as_ff + p_bc_ff;

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      v_ff <= v_in;
   end

   assign u = u_ff;
   assign v = v_ff;
endmodule

// ----- hw/rtl/erst_scale_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scale cell
// Stage 1: floor(v * scale / 2^16). Stage 2: add center for positions,
// pass the rotated value for normals, saturate to the coordinate range.
// center and normal are sampled in the cycle after v.
// ---------------------------------------------------------------------------
module erst_scale_cell #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic signed [COORD_WIDTH+2:0] v,
   input  logic [15:0]                   scale,
   input  logic signed [COORD_WIDTH-1:0] center,
   input  logic                          normal,
   output logic signed [COORD_WIDTH-1:0] out
);
   localparam int VW = COORD_WIDTH + 3;
   localparam int PW = VW + 17;
   localparam int SW = COORD_WIDTH + 4;

   logic signed [PW-1:0]          prod;
   logic signed [PW-1:0]          prod_sh;
   logic signed [VW-1:0]          sc_ff;
   logic signed [VW-1:0]          v_ff;
   logic signed [SW-1:0]          sum;
   logic signed [COORD_WIDTH-1:0] out_in;
   logic signed [COORD_WIDTH-1:0] out_ff;

   assign prod    = v * $signed({1'b0, scale});
   assign prod_sh = prod >>> 16;

   always_ff @(posedge clock) begin
      sc_ff <= prod_sh[VW-1:0];
      v_ff  <= v;
   end

   always_comb begin
      if (normal) begin
         sum = {v_ff[VW-1], v_ff};
      end else begin
         sum = {sc_ff[VW-1], sc_ff} + {{(SW-COORD_WIDTH){center[COORD_WIDTH-1]}}, center};
      end
      if (sum[SW-1:COORD_WIDTH-1] == {(SW-COORD_WIDTH+1){sum[SW-1]}}) begin
         out_in = sum[COORD_WIDTH-1:0];
      end else if (sum[SW-1]) begin
         out_in = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         out_in = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out = out_ff;
endmodule

// ----- tb/sv/tb_euler_rotate_scale_translate.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Euler rotate/scale/translate testbench
// Streams vertices and normals through the block with random start gaps,
// predicts every result in fixed point and compares it field by field.
// The scale register is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_euler_rotate_scale_translate;
   import erst_pkg::*;

   typedef struct {
      logic signed [31:0] vx, vy, vz;
      logic [15:0]        ax, ay, az;
      logic signed [31:0] cx, cy, cz;
      logic               nrm, lst;
   } vertex_type;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic               nrm, lst;
   } xform_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_vert_x = '0, req_vert_y = '0, req_vert_z = '0;
   logic [15:0] req_angle_x = '0, req_angle_y = '0, req_angle_z = '0;
   logic signed [31:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic req_is_normal = 1'b0, req_in_last = 1'b0;
   logic rsp_strobe;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_out_normal, rsp_out_last;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   euler_rotate_scale_translate dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   vertex_type pending_vertices[$];
   xform_type  expected_xforms[$];
   vertex_type cur;
   logic [15:0] scale_q016 = SCALE_RESET;
   bit failed = 0;
   int gap = 0;

   // sin of a binary angle, Q2.30
   function automatic longint sine_q30(logic [15:0] a);
      longint x, z, t, s;
      x = longint'(a[13:0]) <<< 16;
      if (a[14]) x = (longint'(1) <<< 30) - x;
      z = (x * x) >>> 30;
      t = 3864;
      t = 172272 - ((z * t) >>> 30);
      t = 5026994 - ((z * t) >>> 30);
      t = 85569305 - ((z * t) >>> 30);
      t = 693598667 - ((z * t) >>> 30);
      t = 1686629713 - ((z * t) >>> 30);
      s = (x * t) >>> 30;
      if (s > (longint'(1) <<< 30)) s = longint'(1) <<< 30;
      return a[15] ? -s : s;
   endfunction

   function automatic longint frac_mul(longint v, longint m, int sh);
      longint hi, lo;
      hi = v >>> 16;
      lo = v - hi * 65536;
      return (hi * m + ((lo * m) >>> 16)) >>> (sh - 16);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic xform_type transform_vertex(vertex_type v, logic [15:0] sc);
      longint x, y, z, c, s, n1, n2;
      xform_type r;
      x = v.vx; y = v.vy; z = v.vz;
      c = sine_q30(v.ax + 16'h4000); s = sine_q30(v.ax);
      n1 = frac_mul(y, c, 30) - frac_mul(z, s, 30);
      n2 = frac_mul(y, s, 30) + frac_mul(z, c, 30);
      y = n1; z = n2;
      c = sine_q30(v.ay + 16'h4000); s = sine_q30(v.ay);
      n1 = frac_mul(x, c, 30) + frac_mul(z, s, 30);
      n2 = frac_mul(z, c, 30) - frac_mul(x, s, 30);
      x = n1; z = n2;
      c = sine_q30(v.az + 16'h4000); s = sine_q30(v.az);
      n1 = frac_mul(x, c, 30) - frac_mul(y, s, 30);
      n2 = frac_mul(x, s, 30) + frac_mul(y, c, 30);
      x = n1; y = n2;
      if (!v.nrm) begin
         x = frac_mul(x, longint'(sc), 16) + longint'(v.cx);
         y = frac_mul(y, longint'(sc), 16) + longint'(v.cy);
         z = frac_mul(z, longint'(sc), 16) + longint'(v.cz);
      end
      r.x = clamp32(x); r.y = clamp32(y); r.z = clamp32(z);
      r.nrm = v.nrm; r.lst = v.lst;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         automatic bit free = !start;
         if (start && !busy) begin
            expected_xforms.push_back(transform_vertex(cur, scale_q016));
            free = 1;
            case ($urandom_range(99) / 10)
               0, 1: gap = $urandom_range(3, 1);
               2:    gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : 0;
               default: gap = 0;
            endcase
         end
         if (free) begin
            if (gap > 0 || pending_vertices.size() == 0) begin
               if (gap > 0) gap--;
               start <= 1'b0;
            end else begin
               cur = pending_vertices.pop_front();
               start <= 1'b1;
               req_vert_x <= cur.vx; req_vert_y <= cur.vy; req_vert_z <= cur.vz;
               req_angle_x <= cur.ax; req_angle_y <= cur.ay; req_angle_z <= cur.az;
               req_center_x <= cur.cx; req_center_y <= cur.cy; req_center_z <= cur.cz;
               req_is_normal <= cur.nrm; req_in_last <= cur.lst;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_xforms.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                     rsp_out_x, rsp_out_y, rsp_out_z);
            failed = 1;
         end else begin
            automatic xform_type e = expected_xforms.pop_front();
            if (rsp_out_x !== e.x) begin
               $display("%0t: out_x exp %h got %h", $time, e.x, rsp_out_x); failed = 1;
            end
            if (rsp_out_y !== e.y) begin
               $display("%0t: out_y exp %h got %h", $time, e.y, rsp_out_y); failed = 1;
            end
            if (rsp_out_z !== e.z) begin
               $display("%0t: out_z exp %h got %h", $time, e.z, rsp_out_z); failed = 1;
            end
            if (rsp_out_normal !== e.nrm) begin
               $display("%0t: out_normal exp %b got %b", $time, e.nrm, rsp_out_normal);
               failed = 1;
            end
            if (rsp_out_last !== e.lst) begin
               $display("%0t: out_last exp %b got %b", $time, e.lst, rsp_out_last);
               failed = 1;
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic check_scale_readback();
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(0);
      @(posedge clock);
      csr_penable <= 1'b1;
      #1;
      if (csr_prdata[15:0] !== scale_q016) begin
         $display("%0t: scale readback exp %h got %h", $time, scale_q016, csr_prdata);
         failed = 1;
      end
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   task automatic set_scale(logic [15:0] sc);
      csr_write(CSR_ADDR_W'(0), {16'($urandom_range(65535)), sc});
      scale_q016 = sc;
      csr_write(CSR_ADDR_W'(4), $urandom);
      check_scale_readback();
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2097152))) - 32'sd1048576;
         2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(255)
                                     : 32'h80000000 + $urandom_range(255);
         default: return 32'($signed($urandom_range(655360))) - 32'sd327680;
      endcase
   endfunction

   function automatic vertex_type rand_vertex();
      vertex_type v;
      v.vx = rand_coord(); v.vy = rand_coord(); v.vz = rand_coord();
      v.ax = 16'($urandom); v.ay = 16'($urandom); v.az = 16'($urandom);
      if ($urandom_range(7) == 0) v.ax = 16'(16'h4000 * $urandom_range(3));
      v.cx = rand_coord(); v.cy = rand_coord(); v.cz = rand_coord();
      v.nrm = $urandom_range(2) == 0;
      v.lst = $urandom_range(7) == 0;
      return v;
   endfunction

   function automatic vertex_type mk(logic [31:0] p, logic [15:0] a, logic [31:0] c,
                                     logic n, logic l);
      vertex_type v;
      v.vx = p; v.vy = p; v.vz = p;
      v.ax = a; v.ay = a; v.az = a;
      v.cx = c; v.cy = c; v.cz = c;
      v.nrm = n; v.lst = l;
      return v;
   endfunction

   task automatic drain();
      while (pending_vertices.size() != 0 || start || expected_xforms.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      logic [15:0] scales [5] = '{16'd655, 16'd0, 16'd65535, 16'd32768, 16'd0};
      scales[4] = 16'($urandom);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      check_scale_readback();
      set_scale(scales[0]);

      pending_vertices.push_back(mk(32'h0, 16'h0, 32'h0, 1'b0, 1'b0));
      pending_vertices.push_back(mk(32'h7fffffff, 16'h0, 32'h0, 1'b1, 1'b0));
      pending_vertices.push_back(mk(32'h80000000, 16'h0, 32'h0, 1'b1, 1'b1));
      pending_vertices.push_back(mk(32'h7fffffff, 16'h2000, 32'h0, 1'b1, 1'b0));
      pending_vertices.push_back(mk(32'h80000000, 16'he000, 32'h0, 1'b1, 1'b0));
      pending_vertices.push_back(mk(32'h00010000, 16'h4000, 32'h0, 1'b1, 1'b0));
      pending_vertices.push_back(mk(32'h00010000, 16'h8000, 32'h0, 1'b1, 1'b0));
      pending_vertices.push_back(mk(32'h00010000, 16'hc000, 32'h0, 1'b1, 1'b0));
      pending_vertices.push_back(mk(32'h00010000, 16'hffff, 32'h0, 1'b1, 1'b1));
      pending_vertices.push_back(mk(32'h00010000, 16'h0001, 32'h7fffffff, 1'b0, 1'b0));
      pending_vertices.push_back(mk(32'h7fffffff, 16'h0, 32'h7fffffff, 1'b0, 1'b0));
      pending_vertices.push_back(mk(32'h80000000, 16'h0, 32'h80000000, 1'b0, 1'b0));
      pending_vertices.push_back(mk(32'hfffffff0, 16'h1234, 32'h80000000, 1'b0, 1'b1));
      pending_vertices.push_back(mk(32'h00064000, 16'h5555, 32'hffff0000, 1'b0, 1'b0));
      pending_vertices.push_back(mk(32'hffffffff, 16'haaaa, 32'h00000001, 1'b0, 1'b1));
      for (int i = 0; i < 170; i++) pending_vertices.push_back(rand_vertex());
      drain();

      for (int p = 1; p < 5; p++) begin
         set_scale(scales[p]);
         pending_vertices.push_back(mk(32'h7fffffff, 16'h0, 32'h7fffffff, 1'b0, 1'b0));
         pending_vertices.push_back(mk(32'h80000000, 16'h0, 32'h80000000, 1'b0, 1'b1));
         for (int i = 0; i < 190; i++) pending_vertices.push_back(rand_vertex());
         drain();
      end

      if (failed) begin
         $display("FAIL");
      end else begin
         $display("PASS");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule
